// ===== src/uce_pkg.sv =====
// shared types and constants for the universal circuit evaluator
`timescale 1ns / 1ps

package uce_pkg;

   localparam int WIRES     = 1024;
   localparam int ADDR_W    = $clog2(WIRES);
   localparam int COUNT_W   = ADDR_W + 1;
   localparam int ROW_W     = ADDR_W - 1;
   localparam int BANKS     = 2;
   localparam int SRCS      = 3;

   localparam logic [1:0] MAX_ARITY     = 2'd3;
   localparam logic [1:0] MAX_GATE_OUTS = 2'd2;

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_XSWITCH = 3'd1,
      OP_YSELECT = 3'd2,
      OP_UGATE   = 3'd3,
      OP_READ    = 3'd4,
      OP_RESTART = 3'd5
   } op_type;

   typedef struct packed {
      op_type                         opcode;
      logic [SRCS-1:0][ADDR_W-1:0]    src;
      logic [1:0]                     gate_arity;
      logic [1:0]                     gate_outputs;
      logic [7:0]                     table_a;
      logic [7:0]                     table_b;
      logic                           prog_bit;
      logic                           input_bit;
      logic                           last_read;
   } item_type;

   // up to two appends per item, always to consecutive wires
   typedef struct packed {
      logic              we0;
      logic [ADDR_W-1:0] addr0;
      logic              val0;
      logic              we1;
      logic [ADDR_W-1:0] addr1;
      logic              val1;
   } append_type;

endpackage

// ===== src/uce_ram.sv =====
// generic one-write one-read memory with registered read data
`timescale 1ns / 1ps

module uce_ram #(
   parameter int ADDR_W = 9,
   parameter int WIDTH  = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/uce_wire_store.sv =====
// wire store: two parity banks, one copy per read port, plus write forwarding
`timescale 1ns / 1ps

module uce_wire_store (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [uce_pkg::SRCS-1:0][uce_pkg::ADDR_W-1:0] rd_addr,
   input  uce_pkg::append_type                     wr,
   output logic [uce_pkg::SRCS-1:0]                rd_data
);

   import uce_pkg::*;

   logic [SRCS-1:0][ADDR_W-1:0] rd_addr_ff;
   append_type                  fwd_ff;

   logic [BANKS-1:0]            bank_we;
   logic [BANKS-1:0][ROW_W-1:0] bank_addr;
   logic [BANKS-1:0]            bank_val;
   logic [BANKS-1:0][SRCS-1:0]  ram_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
      end else begin
         fwd_ff <= wr;
      end
      rd_addr_ff <= rd_addr;
   end

   // the two appends always land in opposite banks
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      always_comb begin
         bank_we[b]   = 1'b0;
         bank_addr[b] = wr.addr0[ADDR_W-1:1];
         bank_val[b]  = wr.val0;
         if (wr.we0 && (wr.addr0[0] == 1'(b))) begin
            bank_we[b]   = 1'b1;
            bank_addr[b] = wr.addr0[ADDR_W-1:1];
            bank_val[b]  = wr.val0;
         end else if (wr.we1 && (wr.addr1[0] == 1'(b))) begin
            bank_we[b]   = 1'b1;
            bank_addr[b] = wr.addr1[ADDR_W-1:1];
            bank_val[b]  = wr.val1;
         end
      end

      for (genvar i = 0; i < SRCS; i++) begin : g_copy
         uce_ram #(
            .ADDR_W (ROW_W),
            .WIDTH  (1)
         ) u_ram (
            .clock   (clock),
            .wr_en   (bank_we[b]),
            .wr_addr (bank_addr[b]),
            .wr_data (bank_val[b]),
            .rd_addr (rd_addr[i][ADDR_W-1:1]),
            .rd_data (ram_q[b][i])
         );
      end
   end

   // wires appended at the read edge are not yet in the memory
   for (genvar i = 0; i < SRCS; i++) begin : g_read
      always_comb begin
         if (fwd_ff.we1 && (fwd_ff.addr1 == rd_addr_ff[i])) begin
            rd_data[i] = fwd_ff.val1;
         end else if (fwd_ff.we0 && (fwd_ff.addr0 == rd_addr_ff[i])) begin
            rd_data[i] = fwd_ff.val0;
         end else begin
            rd_data[i] = ram_q[rd_addr_ff[i][0]][i];
         end
      end
   end

endmodule

// ===== src/uce_exec.sv =====
// element evaluation: source checks, switch/select/lookup, append and error update
`timescale 1ns / 1ps

module uce_exec (
   input  uce_pkg::item_type               item,
   input  logic                            item_valid,
   input  logic [uce_pkg::SRCS-1:0]        fetch_data,
   input  logic [uce_pkg::COUNT_W-1:0]     count,
   input  logic                            error,
   output uce_pkg::append_type             wr,
   output logic [uce_pkg::COUNT_W-1:0]     count_next,
   output logic                            error_next,
   output logic                            rsp_strobe,
   output logic                            rsp_value,
   output logic                            rsp_err
);

   import uce_pkg::*;

   logic [SRCS-1:0] src_ok;
   logic [SRCS-1:0] src_val;
   logic [SRCS-1:0] src_used;
   logic [1:0]      n_in;
   logic [1:0]      n_out;
   logic [2:0]      lut_idx;
   logic [1:0]      n_app;
   logic            bit0;
   logic            bit1;
   logic            room0;
   logic            room1;
   logic            fetch_err;
   logic            over_err;

   for (genvar i = 0; i < SRCS; i++) begin : g_src
      assign src_ok[i]  = {1'b0, item.src[i]} < count;
      assign src_val[i] = src_ok[i] & fetch_data[i];
   end

   always_comb begin
      n_in = item.gate_arity;
      if (n_in == 2'd0) begin
         n_in = 2'd1;
      end else if (n_in > MAX_ARITY) begin
         n_in = MAX_ARITY;
      end
      n_out = item.gate_outputs;
      if (n_out == 2'd0) begin
         n_out = 2'd1;
      end else if (n_out > MAX_GATE_OUTS) begin
         n_out = MAX_GATE_OUTS;
      end
   end

   // first source is the msb of the lookup index
   always_comb begin
      case (n_in)
         2'd1:    lut_idx = {2'b00, src_val[0]};
         2'd2:    lut_idx = {1'b0, src_val[0], src_val[1]};
         default: lut_idx = {src_val[0], src_val[1], src_val[2]};
      endcase
   end

   always_comb begin
      src_used = '0;
      n_app    = 2'd0;
      bit0     = 1'b0;
      bit1     = 1'b0;
      case (item.opcode)
         OP_LOAD: begin
            n_app = 2'd1;
            bit0  = item.input_bit;
         end
         OP_XSWITCH: begin
            src_used = 3'b011;
            n_app    = 2'd2;
            bit0     = item.prog_bit ? src_val[1] : src_val[0];
            bit1     = item.prog_bit ? src_val[0] : src_val[1];
         end
         OP_YSELECT: begin
            src_used = 3'b011;
            n_app    = 2'd1;
            bit0     = item.prog_bit ? src_val[0] : src_val[1];
         end
         OP_UGATE: begin
            src_used = {n_in == 2'd3, n_in != 2'd1, 1'b1};
            n_app    = n_out;
            bit0     = item.table_a[lut_idx];
            bit1     = item.table_b[lut_idx];
         end
         OP_READ: begin
            src_used = 3'b001;
         end
         default: begin
         end
      endcase
   end

   assign fetch_err = |(src_used & ~src_ok);
   assign room0     = count < COUNT_W'(WIRES);
   assign room1     = count < COUNT_W'(WIRES - 1);
   assign over_err  = ((n_app != 2'd0) && !room0) || ((n_app == 2'd2) && !room1);

   always_comb begin
      wr.we0   = item_valid && (n_app != 2'd0) && room0;
      wr.addr0 = count[ADDR_W-1:0];
      wr.val0  = bit0;
      wr.we1   = item_valid && (n_app == 2'd2) && room1;
      wr.addr1 = count[ADDR_W-1:0] + ADDR_W'(1);
      wr.val1  = bit1;
   end

   always_comb begin
      count_next = count;
      error_next = error;
      if (item_valid) begin
         if (item.opcode == OP_RESTART) begin
            count_next = '0;
            error_next = 1'b0;
         end else begin
            count_next = count + {{(COUNT_W-1){1'b0}}, wr.we0}
                               + {{(COUNT_W-1){1'b0}}, wr.we1};
            error_next = error | fetch_err | over_err;
         end
      end
   end

   assign rsp_strobe = item_valid && (item.opcode == OP_READ);
   assign rsp_value  = src_val[0];
   assign rsp_err    = error | fetch_err;

endmodule

// ===== src/universal_circuit_evaluator.sv =====
// universal circuit evaluator top level
// one item accepted every cycle; busy is never raised and results are never stalled
// a read item's result passes through item_valid_ff and then rsp_valid_ff and is strobed on rsp_valid
// the wire store is read at the accepting edge; wires appended by the previous item are forwarded
// synchronous reset empties the store (wire count zero) and clears the sticky error
// store contents are not cleared: only wires below the count are ever used
`timescale 1ns / 1ps

module universal_circuit_evaluator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_opcode,
   input  logic [uce_pkg::ADDR_W-1:0] req_src0,
   input  logic [uce_pkg::ADDR_W-1:0] req_src1,
   input  logic [uce_pkg::ADDR_W-1:0] req_src2,
   input  logic [1:0]                 req_gate_arity,
   input  logic [1:0]                 req_gate_outputs,
   input  logic [7:0]                 req_table_a,
   input  logic [7:0]                 req_table_b,
   input  logic                       req_prog_bit,
   input  logic                       req_input_bit,
   input  logic                       req_last_read,
   output logic                       rsp_valid,
   output logic                       rsp_wire_value,
   output logic                       rsp_is_last,
   output logic                       rsp_error
);

   import uce_pkg::*;

   item_type             item_in;
   item_type             item_ff;
   logic                 item_valid_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic                 error_ff;
   logic                 error_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_value_ff;
   logic                 rsp_value_in;
   logic                 rsp_last_ff;
   logic                 rsp_err_ff;
   logic                 rsp_err_in;
   logic [SRCS-1:0]      fetch_data;
   append_type           wr;
   logic                 accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      item_in.opcode       = op_type'(req_opcode);
      item_in.src          = {req_src2, req_src1, req_src0};
      item_in.gate_arity   = req_gate_arity;
      item_in.gate_outputs = req_gate_outputs;
      item_in.table_a      = req_table_a;
      item_in.table_b      = req_table_b;
      item_in.prog_bit     = req_prog_bit;
      item_in.input_bit    = req_input_bit;
      item_in.last_read    = req_last_read;
   end

   uce_wire_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (item_in.src),
      .wr      (wr),
      .rd_data (fetch_data)
   );

   uce_exec u_exec (
      .item       (item_ff),
      .item_valid (item_valid_ff),
      .fetch_data (fetch_data),
      .count      (count_ff),
      .error      (error_ff),
      .wr         (wr),
      .count_next (count_in),
      .error_next (error_in),
      .rsp_strobe (rsp_valid_in),
      .rsp_value  (rsp_value_in),
      .rsp_err    (rsp_err_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         count_ff      <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= accept;
         count_ff      <= count_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= item_ff.last_read;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wire_value = rsp_value_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_error      = rsp_err_ff;

endmodule

// ===== tb/tb.sv =====
// testbench for the universal circuit evaluator: directed and random circuits
`timescale 1ns / 1ps

module tb;
   import uce_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [ADDR_W-1:0] src0;
      logic [ADDR_W-1:0] src1;
      logic [ADDR_W-1:0] src2;
      logic [1:0]        gate_arity;
      logic [1:0]        gate_outputs;
      logic [7:0]        table_a;
      logic [7:0]        table_b;
      logic              prog_bit;
      logic              input_bit;
      logic              last_read;
   } elem_type;

   typedef struct packed {
      logic wire_value;
      logic is_last;
      logic error;
   } read_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [2:0]          req_opcode;
   logic [ADDR_W-1:0]   req_src0;
   logic [ADDR_W-1:0]   req_src1;
   logic [ADDR_W-1:0]   req_src2;
   logic [1:0]          req_gate_arity;
   logic [1:0]          req_gate_outputs;
   logic [7:0]          req_table_a;
   logic [7:0]          req_table_b;
   logic                req_prog_bit;
   logic                req_input_bit;
   logic                req_last_read;
   logic                rsp_valid;
   logic                rsp_wire_value;
   logic                rsp_is_last;
   logic                rsp_error;

   // predictor state
   logic                wire_bits [WIRES];
   int                  wire_total = 0;
   logic                sticky_err = 1'b0;
   read_result_type     expected_reads[$];

   int                  failures = 0;
   int                  cycle_count = 0;
   int                  items_sent = 0;
   int                  idle_pct = 0;
   // wires the stimulus side believes are written, used to pick live sources
   int                  shadow_live = 0;

   universal_circuit_evaluator u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_src0         (req_src0),
      .req_src1         (req_src1),
      .req_src2         (req_src2),
      .req_gate_arity   (req_gate_arity),
      .req_gate_outputs (req_gate_outputs),
      .req_table_a      (req_table_a),
      .req_table_b      (req_table_b),
      .req_prog_bit     (req_prog_bit),
      .req_input_bit    (req_input_bit),
      .req_last_read    (req_last_read),
      .rsp_valid        (rsp_valid),
      .rsp_wire_value   (rsp_wire_value),
      .rsp_is_last      (rsp_is_last),
      .rsp_error        (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL universal_circuit_evaluator");
         $finish;
      end
   end

   function automatic logic fetch_wire(input logic [ADDR_W-1:0] idx);
      if (idx >= wire_total) begin
         sticky_err = 1'b1;
         return 1'b0;
      end
      return wire_bits[idx];
   endfunction

   function automatic void append_wire(input logic value);
      if (wire_total >= WIRES) begin
         sticky_err = 1'b1;
      end else begin
         wire_bits[ADDR_W'(wire_total)] = value;
         wire_total++;
      end
   endfunction

   function automatic void predict_element(input elem_type e);
      logic              a;
      logic              b;
      int                n;
      int                m;
      logic [2:0]        sel;
      logic [ADDR_W-1:0] srcs [3];
      read_result_type   r;
      srcs[0] = e.src0;
      srcs[1] = e.src1;
      srcs[2] = e.src2;
      case (e.opcode)
         OP_LOAD: append_wire(e.input_bit);
         OP_XSWITCH: begin
            a = fetch_wire(e.src0);
            b = fetch_wire(e.src1);
            append_wire(e.prog_bit ? b : a);
            append_wire(e.prog_bit ? a : b);
         end
         OP_YSELECT: begin
            a = fetch_wire(e.src0);
            b = fetch_wire(e.src1);
            append_wire(e.prog_bit ? a : b);
         end
         OP_UGATE: begin
            n = (e.gate_arity == 0) ? 1 : int'(e.gate_arity);
            if (n > int'(MAX_ARITY)) n = int'(MAX_ARITY);
            m = (e.gate_outputs == 0) ? 1 : int'(e.gate_outputs);
            if (m > int'(MAX_GATE_OUTS)) m = int'(MAX_GATE_OUTS);
            // first source lands in the msb of the table index
            sel = 3'd0;
            for (int i = 0; i < n; i++) sel = {sel[1:0], fetch_wire(srcs[i])};
            append_wire(e.table_a[sel]);
            if (m > 1) append_wire(e.table_b[sel]);
         end
         OP_READ: begin
            r.wire_value = fetch_wire(e.src0);
            r.is_last    = e.last_read;
            r.error      = sticky_err;
            expected_reads.insert(expected_reads.size(), r);
         end
         OP_RESTART: begin
            wire_total = 0;
            sticky_err = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, actual %0b", name, want, got);
         failures++;
      end
   endfunction

   // check results against the oldest pending read, then predict the accepted item
   always @(posedge clock) begin
      read_result_type want;
      elem_type        seen;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_reads.size() == 0) begin
               $error("result with no read pending: wire_value %0b is_last %0b error %0b",
                      rsp_wire_value, rsp_is_last, rsp_error);
               failures++;
            end else begin
               want = expected_reads.pop_front();
               check_field("wire_value", want.wire_value, rsp_wire_value);
               check_field("is_last", want.is_last, rsp_is_last);
               check_field("error", want.error, rsp_error);
            end
         end
         if (start && !busy) begin
            seen = {req_opcode, req_src0, req_src1, req_src2, req_gate_arity,
                    req_gate_outputs, req_table_a, req_table_b, req_prog_bit,
                    req_input_bit, req_last_read};
            predict_element(seen);
         end
      end
   end

   task automatic send_element(input elem_type e);
      if (idle_pct > 0) begin
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start            <= 1'b1;
      req_opcode       <= e.opcode;
      req_src0         <= e.src0;
      req_src1         <= e.src1;
      req_src2         <= e.src2;
      req_gate_arity   <= e.gate_arity;
      req_gate_outputs <= e.gate_outputs;
      req_table_a      <= e.table_a;
      req_table_b      <= e.table_b;
      req_prog_bit     <= e.prog_bit;
      req_input_bit    <= e.input_bit;
      req_last_read    <= e.last_read;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (e.opcode <= OP_RESTART) items_sent++;
      case (e.opcode)
         OP_LOAD, OP_YSELECT: shadow_live += 1;
         OP_XSWITCH:          shadow_live += 2;
         OP_UGATE:            shadow_live += (e.gate_outputs >= 2) ? 2 : 1;
         OP_RESTART:          shadow_live = 0;
         default: ;
      endcase
      if (shadow_live > WIRES) shadow_live = WIRES;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic elem_type element(input logic [2:0] op, input int s0 = 0,
                                        input int s1 = 0, input int s2 = 0);
      elem_type e;
      e        = '0;
      e.opcode = op;
      e.src0   = ADDR_W'(s0);
      e.src1   = ADDR_W'(s1);
      e.src2   = ADDR_W'(s2);
      return e;
   endfunction

   // mostly live wires; without strict, one pick in ten is anywhere in the index range
   function automatic logic [ADDR_W-1:0] pick_wire(input bit strict);
      if (shadow_live > 0 && (strict || $urandom_range(9) != 0))
         return ADDR_W'($urandom_range(shadow_live - 1));
      return ADDR_W'($urandom_range(WIRES - 1));
   endfunction

   function automatic elem_type rand_element(input logic [2:0] op, input bit strict);
      logic [63:0] raw;
      elem_type    e;
      raw      = {$urandom(), $urandom()};
      e        = raw[$bits(elem_type)-1:0];
      e.opcode = op;
      e.src0   = pick_wire(strict);
      e.src1   = pick_wire(strict);
      e.src2   = pick_wire(strict);
      return e;
   endfunction

   task automatic test_directed();
      elem_type e;
      idle_pct = 0;
      // read of an empty store right after reset
      send_element(element(OP_READ, 0));
      send_element(element(OP_RESTART));
      e = element(OP_LOAD); e.input_bit = 1'b1; send_element(e);
      send_element(element(OP_LOAD));
      e = element(OP_LOAD); e.input_bit = 1'b1; send_element(e);
      send_element(element(OP_XSWITCH, 0, 1));
      e = element(OP_XSWITCH, 0, 1); e.prog_bit = 1'b1; send_element(e);
      e = element(OP_YSELECT, 2, 1); e.prog_bit = 1'b1; send_element(e);
      // unused third source must not raise the error
      send_element(element(OP_YSELECT, 2, 1, WIRES - 1));
      // zero counts act as one input and one output
      e = element(OP_UGATE, 0, WIRES - 1, WIRES - 1); e.table_a = 8'h02; send_element(e);
      // output count above the limit is clamped
      e = element(OP_UGATE, 0, 1, 2);
      e.gate_arity = 2'd3; e.gate_outputs = 2'd3; e.table_a = 8'hFF; e.table_b = 8'h00;
      send_element(e);
      e = element(OP_UGATE, 4, 5, WIRES - 1);
      e.gate_arity = 2'd2; e.gate_outputs = 2'd2; e.table_a = 8'h01; e.table_b = 8'hFE;
      send_element(e);
      e = '1; e.opcode = OP_SPARE6; send_element(e);
      e = '1; e.opcode = OP_SPARE7; send_element(e);
      send_element(element(OP_READ, 12));
      e = element(OP_READ, 13); e.last_read = 1'b1; send_element(e);
      send_element(element(OP_READ, WIRES - 1));
      // error stays set for later good reads
      send_element(element(OP_READ, 9));
      send_element(element(OP_RESTART));
      send_element(element(OP_READ, 0));
      send_element(element(OP_RESTART));
      drain_results();
   endtask

   task automatic test_store_overflow();
      elem_type e;
      idle_pct = 36;
      send_element(rand_element(OP_RESTART, 1'b1));
      repeat (2) send_element(rand_element(OP_LOAD, 1'b1));
      while (shadow_live < WIRES - 2) begin
         if ($urandom_range(15) == 0) begin
            e = rand_element(OP_READ, 1'b1); e.last_read = 1'b0; send_element(e);
         end else begin
            send_element(rand_element(OP_XSWITCH, 1'b1));
         end
      end
      e = rand_element(OP_UGATE, 1'b1); e.gate_outputs = 2'd1; send_element(e);
      // one slot left, no error yet
      e = element(OP_READ, WIRES - 2); send_element(e);
      // switch with room for one appends only its first wire
      send_element(rand_element(OP_XSWITCH, 1'b1));
      send_element(element(OP_READ, WIRES - 1));
      send_element(rand_element(OP_LOAD, 1'b1));
      e = element(OP_READ, WIRES - 1); e.last_read = 1'b1; send_element(e);
      send_element(rand_element(OP_RESTART, 1'b1));
      drain_results();
   endtask

   task automatic test_random_circuits(input int count, input int idle);
      elem_type   e;
      int         first;
      int         r;
      int         reads;
      logic [2:0] op;
      idle_pct = idle;
      first    = items_sent;
      while (items_sent - first < count) begin
         if ($urandom_range(9) == 0) begin
            // broken sequence: any opcode in any order, sources anywhere
            repeat ($urandom_range(5, 30))
               send_element(rand_element(3'($urandom_range(OP_SPARE7)), 1'b0));
         end else begin
            send_element(rand_element(OP_RESTART, 1'b0));
            repeat ($urandom_range(1, 8)) send_element(rand_element(OP_LOAD, 1'b0));
            repeat ($urandom_range(4, 40)) begin
               r = $urandom_range(99);
               if (r < 30)      op = OP_XSWITCH;
               else if (r < 50) op = OP_YSELECT;
               else if (r < 85) op = OP_UGATE;
               else if (r < 93) op = OP_LOAD;
               else             op = OP_READ;
               send_element(rand_element(op, 1'b0));
            end
            reads = $urandom_range(1, 4);
            for (int i = 0; i < reads; i++) begin
               e = rand_element(OP_READ, 1'b0);
               e.last_read = (i == reads - 1);
               send_element(e);
            end
         end
      end
      drain_results();
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = '0;
      req_src0         = '0;
      req_src1         = '0;
      req_src2         = '0;
      req_gate_arity   = '0;
      req_gate_outputs = '0;
      req_table_a      = '0;
      req_table_b      = '0;
      req_prog_bit     = 1'b0;
      req_input_bit    = 1'b0;
      req_last_read    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_store_overflow();
      test_random_circuits(170, 0);
      test_random_circuits(170, 83);
      test_random_circuits(170, 36);

      if (failures == 0 && expected_reads.size() == 0) begin
         $display("PASS universal_circuit_evaluator");
      end else begin
         $display("FAIL universal_circuit_evaluator");
      end
      $finish;
   end

endmodule

// ===== universal_circuit_evaluator.f =====
src/uce_pkg.sv
src/uce_ram.sv
src/uce_wire_store.sv
src/uce_exec.sv
src/universal_circuit_evaluator.sv
tb/tb.sv
